### hdl/xlsd_pkg.sv
// Shared types, opcode constants and byte-select helpers for the load/store decoder.
`timescale 1ns / 1ps

package xlsd_pkg;

    localparam int WIN_BYTES = 14;
    localparam int WIN_BITS  = WIN_BYTES * 8;

    localparam logic [3:0] REX_PREFIX_HI = 4'h4;
    localparam logic [7:0] OP_ESCAPE     = 8'h0F;
    localparam logic [7:0] OP_ESCAPE_38  = 8'h38;
    localparam logic [7:0] OP_MOVBE_LD   = 8'hF0;
    localparam logic [7:0] OP_MOVBE_ST   = 8'hF1;
    localparam logic [7:0] OP_MOV_ST     = 8'h89;
    localparam logic [7:0] OP_MOV_LD     = 8'h8B;
    localparam logic [7:0] OP_MOV_IMM    = 8'hC7;

    localparam logic [1:0] MOD_NO_DISP   = 2'b00;
    localparam logic [1:0] MOD_DISP8     = 2'b01;
    localparam logic [1:0] MOD_DISP32    = 2'b10;

    localparam logic [2:0] RM_SIB        = 3'b100;
    localparam logic [2:0] RM_DISP32     = 3'b101;
    localparam logic [2:0] SIB_NO_INDEX  = 3'b100;
    localparam logic [2:0] SIB_NO_BASE   = 3'b101;

    localparam int REX_B = 0;
    localparam int REX_X = 1;
    localparam int REX_R = 2;

    typedef logic [WIN_BITS-1:0] window_t;

    typedef struct packed {
        logic [63:0] bytes_low;
        logic [47:0] bytes_high;
    } in_item_t;

    typedef struct packed {
        logic               valid_res;
        logic               is_load;
        logic               is_movbe;
        logic               imm_store;
        logic [3:0]         data_gpr;
        logic [3:0]         base_reg;
        logic               has_index;
        logic [3:0]         index_reg;
        logic [3:0]         scale;
        logic signed [31:0] displacement;
        logic signed [31:0] immediate;
        logic [3:0]         length;
    } out_item_t;

    function automatic logic [7:0] win_byte(input window_t win, input logic [3:0] idx);
        logic [7:0] b;
        b = 8'h00;
        for (int k = 0; k < WIN_BYTES; k++)
        begin
            if (idx == 4'(k))
            begin
                b = win[8*k +: 8];
            end
        end
        return b;
    endfunction

    function automatic logic [31:0] win_le32(input window_t win, input logic [3:0] idx);
        return {win_byte(win, idx + 4'd3), win_byte(win, idx + 4'd2),
                win_byte(win, idx + 4'd1), win_byte(win, idx)};
    endfunction

endpackage

### hdl/xlsd_if.sv
// Valid/ready channel interfaces for instruction windows and decode results.
`timescale 1ns / 1ps

interface xlsd_in_if;
    logic                valid;
    logic                ready;
    xlsd_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface xlsd_out_if;
    logic                valid;
    logic                ready;
    xlsd_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/x86_load_store_decoder.sv
// Three-stage pipelined decoder of x86-64 32-bit MOV/MOVBE memory moves.
`timescale 1ns / 1ps

//  channel   dir   beat payload
//  in_ch     in    bytes_low[63:0], bytes_high[47:0]
//  out_ch    out   decode result (registers, scale, displacement, immediate, length)
//
//  One beat per cycle sustained while the output is not stalled; three register
//  stages, so a result passes s1_reg, s2_reg and s3_reg before it is offered.
//  Stage 1 finds REX and the opcode, stage 2 reads ModRM/SIB, stage 3 reads
//  displacement and immediate into the output register.
//  rst_n clears the stage valid bits only; payload registers are not reset.
//  A stalled output holds each full stage whose later stages are all full; empty stages keep filling.

module x86_load_store_decoder
(
    input  logic           clk,
    input  logic           rst_n,
    xlsd_in_if.sink        in_ch,
    xlsd_out_if.source     out_ch
);
    import xlsd_pkg::*;

    typedef struct packed {
        window_t    win;
        logic [2:0] rex;
        logic       rej;
        logic       is_load;
        logic       is_movbe;
        logic       imm_store;
        logic [2:0] modrm_pos;
    } s1_t;

    typedef struct packed {
        window_t    win;
        logic       rej;
        logic       is_load;
        logic       is_movbe;
        logic       imm_store;
        logic [1:0] mod;
        logic [3:0] data_gpr;
        logic [3:0] base_reg;
        logic       has_index;
        logic [3:0] index_reg;
        logic [3:0] scale;
        logic [3:0] disp_pos;
    } s2_t;

    logic      v1_reg, v2_reg, v3_reg;
    s1_t       s1_reg, s1_next;
    s2_t       s2_reg, s2_next;
    out_item_t s3_reg, s3_next;
    logic      en1, en2, en3;

    assign en3 = !v3_reg || out_ch.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign in_ch.ready  = en1;
    assign out_ch.valid = v3_reg;
    assign out_ch.data  = s3_reg;

    // stage 1: prefix and opcode
    always_comb
    begin
        window_t    w;
        logic       rex_hit;
        logic [7:0] op0, op1, op2;
        logic       esc;
        w       = {in_ch.data.bytes_high, in_ch.data.bytes_low};
        rex_hit = (w[7:4] == REX_PREFIX_HI);
        op0     = rex_hit ? w[15:8]  : w[7:0];
        op1     = rex_hit ? w[23:16] : w[15:8];
        op2     = rex_hit ? w[31:24] : w[23:16];
        esc     = (op0 == OP_ESCAPE) && (op1 == OP_ESCAPE_38);

        s1_next.win       = w;
        s1_next.rex       = rex_hit ? w[2:0] : 3'b000;
        s1_next.rej       = 1'b0;
        s1_next.is_load   = 1'b0;
        s1_next.is_movbe  = 1'b0;
        s1_next.imm_store = 1'b0;
        s1_next.modrm_pos = {2'b00, rex_hit} + 3'd1;
        priority if (esc && op2 == OP_MOVBE_ST)
        begin
            s1_next.is_movbe  = 1'b1;
            s1_next.modrm_pos = {2'b00, rex_hit} + 3'd3;
        end
        else if (esc && op2 == OP_MOVBE_LD)
        begin
            s1_next.is_movbe  = 1'b1;
            s1_next.is_load   = 1'b1;
            s1_next.modrm_pos = {2'b00, rex_hit} + 3'd3;
        end
        else if (op0 == OP_MOV_ST)
        begin
            s1_next.rej = 1'b0;
        end
        else if (op0 == OP_MOV_LD)
        begin
            s1_next.is_load = 1'b1;
        end
        else if (op0 == OP_MOV_IMM)
        begin
            s1_next.imm_store = 1'b1;
        end
        else
        begin
            s1_next.rej = 1'b1;
        end
    end

    // stage 2: ModRM and SIB
    always_comb
    begin
        logic [7:0] modrm, sib;
        logic [1:0] md;
        logic [2:0] rm;
        logic       has_sib;
        modrm   = win_byte(s1_reg.win, {1'b0, s1_reg.modrm_pos});
        sib     = win_byte(s1_reg.win, {1'b0, s1_reg.modrm_pos} + 4'd1);
        md      = modrm[7:6];
        rm      = modrm[2:0];
        has_sib = (rm == RM_SIB);

        s2_next.win         = s1_reg.win;
        s2_next.is_load     = s1_reg.is_load;
        s2_next.is_movbe    = s1_reg.is_movbe;
        s2_next.imm_store   = s1_reg.imm_store;
        s2_next.mod         = md;
        s2_next.data_gpr    = {s1_reg.rex[REX_R], modrm[5:3]};
        s2_next.rej         = s1_reg.rej || (rm == RM_DISP32 && md == MOD_NO_DISP)
                              || (has_sib && sib[2:0] == SIB_NO_BASE);
        s2_next.disp_pos    = {1'b0, s1_reg.modrm_pos} + 4'd1 + {3'b000, has_sib};
        s2_next.has_index   = 1'b0;
        s2_next.index_reg   = 4'd0;
        s2_next.scale       = 4'd1;
        s2_next.base_reg    = {s1_reg.rex[REX_B], rm};
        if (has_sib)
        begin
            s2_next.scale    = 4'd1 << sib[7:6];
            s2_next.base_reg = {s1_reg.rex[REX_B], sib[2:0]};
            if (sib[5:3] != SIB_NO_INDEX)
            begin
                s2_next.has_index = 1'b1;
                s2_next.index_reg = {s1_reg.rex[REX_X], sib[5:3]};
            end
        end
    end

    // stage 3: displacement, immediate, length
    always_comb
    begin
        logic [7:0]  d8;
        logic [31:0] disp;
        logic [3:0]  imm_pos;
        d8 = win_byte(s2_reg.win, s2_reg.disp_pos);
        unique case (s2_reg.mod)
            MOD_DISP8:
            begin
                disp    = {{24{d8[7]}}, d8};
                imm_pos = s2_reg.disp_pos + 4'd1;
            end
            MOD_DISP32:
            begin
                disp    = win_le32(s2_reg.win, s2_reg.disp_pos);
                imm_pos = s2_reg.disp_pos + 4'd4;
            end
            default:
            begin
                disp    = 32'd0;
                imm_pos = s2_reg.disp_pos;
            end
        endcase

        s3_next = '0;
        if (!s2_reg.rej)
        begin
            s3_next.valid_res    = 1'b1;
            s3_next.is_load      = s2_reg.is_load;
            s3_next.is_movbe     = s2_reg.is_movbe;
            s3_next.imm_store    = s2_reg.imm_store;
            s3_next.data_gpr     = s2_reg.data_gpr;
            s3_next.base_reg     = s2_reg.base_reg;
            s3_next.has_index    = s2_reg.has_index;
            s3_next.index_reg    = s2_reg.index_reg;
            s3_next.scale        = s2_reg.scale;
            s3_next.displacement = disp;
            s3_next.immediate    = s2_reg.imm_store ? win_le32(s2_reg.win, imm_pos) : 32'd0;
            s3_next.length       = s2_reg.imm_store ? imm_pos + 4'd4 : imm_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_ch.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
        if (en2)
        begin
            s2_reg <= s2_next;
        end
        if (en3)
        begin
            s3_reg <= s3_next;
        end
    end

endmodule
